/* rtl/core/ests_pkg.sv */
// ----------------------------------------------------------------------------
// ests_pkg: shared constants for the small tour search
// Field widths, operation, status and register index codes.
// ----------------------------------------------------------------------------
package ests_pkg;
    localparam int CITY_BITS    = 3;
    localparam int DIST_IN_BITS = 16;
    localparam int COST_BITS    = 19;
    localparam int COUNT_BITS   = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    localparam logic CFG_CITY_COUNT = 1'b0;
    localparam logic CFG_STOP       = 1'b1;

    typedef logic [CITY_BITS-1:0] t_city;
endpackage

/* rtl/core/ests_dist_mem.sv */
// ----------------------------------------------------------------------------
// ests_dist_mem: distance matrix store
// One write port and one registered read port, addressed by row and column city.
// ----------------------------------------------------------------------------
module ests_dist_mem #(
    parameter int MAX_CITIES = 8,
    parameter int WIDTH      = 16
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  ests_pkg::t_city    i_wr_from,
    input  ests_pkg::t_city    i_wr_to,
    input  logic [WIDTH-1:0]   i_wr_data,
    input  ests_pkg::t_city    i_rd_from,
    input  ests_pkg::t_city    i_rd_to,
    output logic [WIDTH-1:0]   o_rd_data
);
    import ests_pkg::*;

    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic             wr_ok;

    assign wr_ok = (32'(i_wr_from) < MAX_CITIES) && (32'(i_wr_to) < MAX_CITIES);
    assign waddr = AW'(32'(i_wr_from) * MAX_CITIES + 32'(i_wr_to));
    assign raddr = AW'(32'(i_rd_from) * MAX_CITIES + 32'(i_rd_to));

    always_ff @(posedge i_clk) begin
        if (i_we && wr_ok) begin
            mem[waddr] <= i_wr_data;
        end
        o_rd_data <= mem[raddr];
    end
endmodule

/* rtl/core/exhaustive_small_tour_search.sv */
// ----------------------------------------------------------------------------
// exhaustive_small_tour_search: brute-force closed tour search
// Loads a distance matrix, then enumerates every tour from city 0.
// ----------------------------------------------------------------------------
// A start transfer walks the tours of cities 1..n-1 in lexicographic order,
// stopping at a new best cost at or below the stop value. Each tour is summed
// via the single distance memory read port into one accumulator (n reads, a
// read wait, a compare, an order step). The block is not ready during the
// search, at most 5040 tours for eight cities, then emits n results (one
// ST_BAD for bad n) via an output register, one per cycle when the sink is ready.
module exhaustive_small_tour_search #(
    parameter int MAX_CITIES    = 8,
    parameter int DISTANCE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // from_city[2:0], to_city[5:3], distance[21:6]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // city[2:0], previous_city[5:3], next_city[8:6],
                                       // tour_cost[27:9]
    output logic        m_axis_tuser,  // status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [18:0] i_cfg_data
);
    import ests_pkg::*;

    localparam int STORE_BITS = (DISTANCE_BITS < DIST_IN_BITS) ? DISTANCE_BITS : DIST_IN_BITS;
    localparam int PB         = (MAX_CITIES > 2) ? $clog2(MAX_CITIES) : 1;
    localparam int SUM_BITS   = STORE_BITS + PB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_ADV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            r_state;
    logic [COUNT_BITS-1:0] r_city_count;
    logic [COST_BITS-1:0]  r_stop;
    logic [COUNT_BITS-1:0] r_n;
    logic                  r_err;
    logic [PB-1:0]         r_leg;
    logic [PB-1:0]         r_oi;
    logic                  r_rdv;
    logic                  r_found;
    logic [SUM_BITS-1:0]   r_sum;
    logic [SUM_BITS-1:0]   r_best;
    t_city                 r_cur  [MAX_CITIES];
    t_city                 r_bord [MAX_CITIES];
    t_city                 n_cur  [MAX_CITIES];
    logic                  n_more;

    logic                  r_ov;
    logic [31:0]           r_odata;
    logic                  r_ouser;
    logic                  r_olast;

    logic                  in_xfer;
    logic                  out_free;
    logic [PB-1:0]         nm1;
    logic [PB-1:0]         leg_nx;
    logic [STORE_BITS-1:0] rd_data;
    logic                  bad_n;
    logic [PB-1:0]         oi_prev;
    logic [PB-1:0]         oi_next;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_ov || m_axis_tready;
    assign nm1           = PB'(r_n - COUNT_BITS'(1));
    assign leg_nx        = (r_leg == nm1) ? '0 : PB'(r_leg + PB'(1));
    assign bad_n         = (r_city_count < COUNT_BITS'(2)) ||
                           (32'(r_city_count) > MAX_CITIES);
    assign oi_prev       = (r_oi == '0) ? nm1 : PB'(r_oi - PB'(1));
    assign oi_next       = (r_oi == nm1) ? '0 : PB'(r_oi + PB'(1));

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    ests_dist_mem #(
        .MAX_CITIES (MAX_CITIES),
        .WIDTH      (STORE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (in_xfer && (s_axis_tuser == OP_LOAD)),
        .i_wr_from (s_axis_tdata[2:0]),
        .i_wr_to   (s_axis_tdata[5:3]),
        .i_wr_data (s_axis_tdata[6 +: STORE_BITS]),
        .i_rd_from (r_cur[r_leg]),
        .i_rd_to   (r_cur[leg_nx]),
        .o_rd_data (rd_data)
    );

    // next lexicographic order of positions 1..n-1
    always_comb begin
        int    piv;
        int    jj;
        t_city sw [MAX_CITIES];
        piv    = 0;
        jj     = 0;
        n_more = 1'b0;
        for (int k = 1; k < MAX_CITIES - 1; k++) begin
            if ((k + 1 < int'(r_n)) && (r_cur[k] < r_cur[k+1])) begin
                piv    = k;
                n_more = 1'b1;
            end
        end
        for (int k = 1; k < MAX_CITIES; k++) begin
            if ((k > piv) && (k < int'(r_n)) && (r_cur[k] > r_cur[piv])) begin
                jj = k;
            end
        end
        for (int k = 0; k < MAX_CITIES; k++) begin
            sw[k] = r_cur[k];
        end
        sw[PB'(piv)] = r_cur[PB'(jj)];
        sw[PB'(jj)]  = r_cur[PB'(piv)];
        for (int k = 0; k < MAX_CITIES; k++) begin
            if ((k > piv) && (k < int'(r_n))) begin
                n_cur[k] = sw[PB'(int'(r_n) + piv - k)];
            end else begin
                n_cur[k] = sw[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_city_count <= COUNT_BITS'(8);
            r_stop       <= COST_BITS'(1);
            r_ov         <= 1'b0;
            r_rdv        <= 1'b0;
            r_found      <= 1'b0;
            r_leg        <= '0;
            r_oi         <= '0;
            r_err        <= 1'b0;
            r_n          <= '0;
            for (int k = 0; k < MAX_CITIES; k++) begin
                r_cur[k]  <= t_city'(k);
                r_bord[k] <= t_city'(k);
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CITY_COUNT: r_city_count <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_STOP:       r_stop       <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            r_rdv <= (r_state == S_SUM);
            if (r_rdv) begin
                r_sum <= r_sum + SUM_BITS'(rd_data);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (s_axis_tuser == OP_START)) begin
                        r_oi <= '0;
                        if (bad_n) begin
                            r_err   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_err   <= 1'b0;
                            r_n     <= r_city_count;
                            r_found <= 1'b0;
                            r_leg   <= '0;
                            r_sum   <= '0;
                            for (int k = 0; k < MAX_CITIES; k++) begin
                                r_cur[k] <= t_city'(k);
                            end
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    if (r_leg == nm1) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_leg <= PB'(r_leg + PB'(1));
                    end
                end
                S_WAIT: r_state <= S_CMP;
                S_CMP: begin
                    if (!r_found || (r_sum < r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= r_sum;
                        for (int k = 0; k < MAX_CITIES; k++) begin
                            r_bord[k] <= r_cur[k];
                        end
                        r_state <= (COST_BITS'(r_sum) <= r_stop) ? S_OUT : S_ADV;
                    end else begin
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    if (n_more) begin
                        for (int k = 0; k < MAX_CITIES; k++) begin
                            r_cur[k] <= n_cur[k];
                        end
                        r_leg   <= '0;
                        r_sum   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        if (r_err) begin
                            r_odata <= '0;
                            r_ouser <= ST_BAD;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_odata <= {4'd0, COST_BITS'(r_best), r_bord[oi_next],
                                        r_bord[oi_prev], r_bord[r_oi]};
                            r_ouser <= ST_OK;
                            r_olast <= (r_oi == nm1);
                            r_oi    <= PB'(r_oi + PB'(1));
                            if (r_oi == nm1) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
